// ----- sv/wsfe_pkg.sv -----
// Package: payload structs, run struct, framing constants and key byte helper.
`timescale 1ns / 1ps

package wsfe_pkg;

    localparam int MAX_RUN = 14;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [31:0] LEN_16_MAX = 32'd65535;

    typedef struct packed {
        logic        operation;
        logic        fin;
        logic [3:0]  opcode;
        logic        mask_en;
        logic [31:0] payload_length;
        logic [31:0] mask_key;
        logic [7:0]  data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_last;
    } t_out;

    // A run of bytes caused by one item; element 0 goes out first.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
        logic                    frame_last;
    } t_run;

    function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] kb;
        unique case (idx)
            2'd0: kb = key[31:24];
            2'd1: kb = key[23:16];
            2'd2: kb = key[15:8];
            default: kb = key[7:0];
        endcase
        return kb;
    endfunction

endpackage

// ----- sv/websocket_frame_encoder_top.sv -----
// Top level of the WebSocket frame encoder.
`timescale 1ns / 1ps

// WebSocket (RFC 6455) frame encoder producing the frame as a byte stream.
// A header transfer (operation 0) yields a run of 2 to 14 bytes: FIN/opcode,
// MASK/length code, a 2- or 8-byte big-endian extended length and, with
// masking on, the four key bytes. A payload transfer (operation 1) yields one
// byte, XORed with key byte (index mod 4) when masking is on; a payload
// transfer while no frame is open yields nothing. run_last marks the final
// byte of each run and frame_last the final byte of the frame (the last header
// byte for an empty frame). A new header abandons any open frame. Rate: a
// payload byte is taken every cycle while the output keeps pace; a header
// occupies the output for one transfer per header byte (2 to 14), since the
// result register holds one run and sends a byte per transfer. Input ready
// follows the output ready combinationally while the run's last byte is shown.

module websocket_frame_encoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wsfe_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output wsfe_pkg::t_out o_out_data
);

    wsfe_pkg::t_run run;
    logic           accept;
    logic           load_run;
    logic           room;

    // take a new transfer when the result register is free or drains now
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;
    // load only runs with bytes; a payload with no open frame just drops
    assign load_run   = accept && (run.count != '0);

    wsfe_encode u_encode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_item  (i_in_data),
        .o_run   (run)
    );

    wsfe_run_out u_run_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load_run),
        .i_run        (run),
        .o_empty_next (room),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (o_out_data)
    );

endmodule

// ----- sv/wsfe_encode.sv -----
// Frame state and construction of the byte run for one accepted item.
`timescale 1ns / 1ps

module wsfe_encode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  wsfe_pkg::t_in  i_item,
    output wsfe_pkg::t_run o_run
);

    logic [31:0] r_remaining, n_remaining;
    logic [31:0] r_key, n_key;
    logic        r_mask, n_mask;
    logic [1:0]  r_kidx, n_kidx;

    logic [7:0] byte_hdr1;
    logic [7:0] len_byte;
    logic       msk_bit;

    always_comb begin
        o_run       = '0;
        n_remaining = r_remaining;
        n_key       = r_key;
        n_mask      = r_mask;
        n_kidx      = r_kidx;
        msk_bit     = i_item.mask_en;
        byte_hdr1   = {i_item.fin, 3'b000, i_item.opcode};
        len_byte    = 8'h00;

        if (i_item.operation == wsfe_pkg::OP_HEADER) begin
            o_run.bytes[0] = byte_hdr1;
            // the key follows straight after the length bytes
            if (i_item.payload_length < {25'd0, wsfe_pkg::LEN_CODE_16}) begin
                len_byte       = {msk_bit, i_item.payload_length[6:0]};
                o_run.bytes[1] = len_byte;
                o_run.count    = wsfe_pkg::RUN_CNT_W'(2);
                if (msk_bit) begin
                    o_run.bytes[2] = wsfe_pkg::key_byte(i_item.mask_key, 2'd0);
                    o_run.bytes[3] = wsfe_pkg::key_byte(i_item.mask_key, 2'd1);
                    o_run.bytes[4] = wsfe_pkg::key_byte(i_item.mask_key, 2'd2);
                    o_run.bytes[5] = wsfe_pkg::key_byte(i_item.mask_key, 2'd3);
                end
            end else if (i_item.payload_length <= wsfe_pkg::LEN_16_MAX) begin
                len_byte       = {msk_bit, wsfe_pkg::LEN_CODE_16};
                o_run.bytes[1] = len_byte;
                o_run.bytes[2] = i_item.payload_length[15:8];
                o_run.bytes[3] = i_item.payload_length[7:0];
                o_run.count    = wsfe_pkg::RUN_CNT_W'(4);
                if (msk_bit) begin
                    o_run.bytes[4] = wsfe_pkg::key_byte(i_item.mask_key, 2'd0);
                    o_run.bytes[5] = wsfe_pkg::key_byte(i_item.mask_key, 2'd1);
                    o_run.bytes[6] = wsfe_pkg::key_byte(i_item.mask_key, 2'd2);
                    o_run.bytes[7] = wsfe_pkg::key_byte(i_item.mask_key, 2'd3);
                end
            end else begin
                len_byte       = {msk_bit, wsfe_pkg::LEN_CODE_64};
                o_run.bytes[1] = len_byte;
                o_run.bytes[6] = i_item.payload_length[31:24];
                o_run.bytes[7] = i_item.payload_length[23:16];
                o_run.bytes[8] = i_item.payload_length[15:8];
                o_run.bytes[9] = i_item.payload_length[7:0];
                o_run.count    = wsfe_pkg::RUN_CNT_W'(10);
                if (msk_bit) begin
                    o_run.bytes[10] = wsfe_pkg::key_byte(i_item.mask_key, 2'd0);
                    o_run.bytes[11] = wsfe_pkg::key_byte(i_item.mask_key, 2'd1);
                    o_run.bytes[12] = wsfe_pkg::key_byte(i_item.mask_key, 2'd2);
                    o_run.bytes[13] = wsfe_pkg::key_byte(i_item.mask_key, 2'd3);
                end
            end
            if (msk_bit) begin
                o_run.count = o_run.count + wsfe_pkg::RUN_CNT_W'(4);
            end
            o_run.frame_last = (i_item.payload_length == 32'd0);
            if (i_load) begin
                n_remaining = i_item.payload_length;
                n_key       = i_item.mask_key;
                n_mask      = i_item.mask_en;
                n_kidx      = 2'd0;
            end
        end else if (r_remaining != 32'd0) begin
            o_run.bytes[0]   = r_mask ? (i_item.data_byte ^ wsfe_pkg::key_byte(r_key, r_kidx))
                                      : i_item.data_byte;
            o_run.count      = wsfe_pkg::RUN_CNT_W'(1);
            o_run.frame_last = (r_remaining == 32'd1);
            if (i_load) begin
                n_remaining = r_remaining - 32'd1;
                n_kidx      = r_kidx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_key       <= '0;
            r_mask      <= 1'b0;
            r_kidx      <= '0;
        end else begin
            r_remaining <= n_remaining;
            r_key       <= n_key;
            r_mask      <= n_mask;
            r_kidx      <= n_kidx;
        end
    end

endmodule

// ----- sv/wsfe_run_out.sv -----
// Result register: holds one byte run and sends it out a byte per transfer.
`timescale 1ns / 1ps

module wsfe_run_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  wsfe_pkg::t_run i_run,
    output logic           o_empty_next,
    output logic           o_valid,
    input  logic           i_ready,
    output wsfe_pkg::t_out o_data
);

    logic [wsfe_pkg::MAX_RUN-1:0][7:0] r_bytes, n_bytes;
    logic [wsfe_pkg::RUN_CNT_W-1:0]    r_count, n_count;
    logic                              r_flast, n_flast;
    logic                              take;

    assign o_valid = (r_count != '0);
    assign take    = o_valid && i_ready;
    // free now, or the last byte leaves this cycle
    assign o_empty_next = (r_count == '0) ||
                          ((r_count == wsfe_pkg::RUN_CNT_W'(1)) && i_ready);

    assign o_data.out_byte   = r_bytes[0];
    assign o_data.run_last   = (r_count == wsfe_pkg::RUN_CNT_W'(1));
    assign o_data.frame_last = (r_count == wsfe_pkg::RUN_CNT_W'(1)) && r_flast;

    always_comb begin
        n_bytes = r_bytes;
        n_count = r_count;
        n_flast = r_flast;
        if (i_load) begin
            n_bytes = i_run.bytes;
            n_count = i_run.count;
            n_flast = i_run.frame_last;
        end else if (take) begin
            for (int k = 0; k < wsfe_pkg::MAX_RUN - 1; k++) begin
                n_bytes[k] = r_bytes[k + 1];
            end
            n_bytes[wsfe_pkg::MAX_RUN-1] = 8'h00;
            n_count = r_count - wsfe_pkg::RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flast <= 1'b0;
        end else begin
            r_count <= n_count;
            r_flast <= n_flast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule
